FILE: design/lmsm_pkg.sv
`timescale 1ns / 1ps

package lmsm_pkg;

  localparam int SCAN_LINES   = 15;
  localparam int CHANNELS     = 15;
  localparam int FRAME_ROWS   = 11;
  localparam int FRAME_COLS   = 7;
  localparam int COLOR_PLANES = 3;
  localparam int PIXELS       = CHANNELS / COLOR_PLANES;
  localparam int STORE_DEPTH  = FRAME_ROWS * FRAME_COLS * COLOR_PLANES;

  localparam logic [3:0] LAST_CHANNEL   = 4'(CHANNELS - 1);
  localparam logic [3:0] LAST_LINE      = 4'(SCAN_LINES - 1);
  localparam logic [3:0] PRE_DOUBLE_LINE = 4'd6;
  localparam logic [3:0] SHARED_LINE_A  = 4'd2;
  localparam logic [3:0] SHARED_LINE_B  = 4'd6;
  localparam logic [1:0] TOP_PLANE      = 2'(COLOR_PLANES - 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic start;
    logic wr;
    logic issue;
  } lmsm_cmd_t;

  typedef struct packed {
    logic ch_last;
  } lmsm_stat_t;

  // {row, col} of each three-channel pixel group, per scan line
  localparam logic [6:0] SCAN_RC [SCAN_LINES][PIXELS] = '{
    '{{4'd5, 3'd5}, {4'd5, 3'd4}, {4'd5, 3'd3}, {4'd5, 3'd2}, {4'd5, 3'd1}},
    '{{4'd4, 3'd4}, {4'd3, 3'd4}, {4'd2, 3'd4}, {4'd1, 3'd4}, {4'd0, 3'd4}},
    '{{4'd7, 3'd6}, {4'd8, 3'd0}, {4'd9, 3'd0}, {4'd10, 3'd4}, {4'd7, 3'd0}},
    '{{4'd8, 3'd5}, {4'd8, 3'd1}, {4'd8, 3'd2}, {4'd8, 3'd4}, {4'd8, 3'd3}},
    '{{4'd4, 3'd5}, {4'd3, 3'd5}, {4'd2, 3'd5}, {4'd1, 3'd5}, {4'd0, 3'd5}},
    '{{4'd4, 3'd6}, {4'd3, 3'd6}, {4'd2, 3'd6}, {4'd1, 3'd6}, {4'd0, 3'd6}},
    '{{4'd7, 3'd6}, {4'd6, 3'd6}, {4'd5, 3'd6}, {4'd6, 3'd0}, {4'd5, 3'd0}},
    '{{4'd4, 3'd3}, {4'd3, 3'd3}, {4'd2, 3'd3}, {4'd1, 3'd3}, {4'd0, 3'd3}},
    '{{4'd10, 3'd3}, {4'd10, 3'd0}, {4'd10, 3'd1}, {4'd10, 3'd2}, {4'd10, 3'd5}},
    '{{4'd4, 3'd1}, {4'd3, 3'd1}, {4'd2, 3'd1}, {4'd1, 3'd1}, {4'd0, 3'd1}},
    '{{4'd4, 3'd0}, {4'd3, 3'd0}, {4'd2, 3'd0}, {4'd1, 3'd0}, {4'd0, 3'd0}},
    '{{4'd7, 3'd5}, {4'd7, 3'd4}, {4'd7, 3'd3}, {4'd7, 3'd2}, {4'd7, 3'd1}},
    '{{4'd4, 3'd2}, {4'd3, 3'd2}, {4'd2, 3'd2}, {4'd1, 3'd2}, {4'd0, 3'd2}},
    '{{4'd6, 3'd5}, {4'd6, 3'd4}, {4'd6, 3'd3}, {4'd6, 3'd2}, {4'd6, 3'd1}},
    '{{4'd9, 3'd3}, {4'd9, 3'd4}, {4'd9, 3'd1}, {4'd9, 3'd2}, {4'd9, 3'd5}}
  };

  function automatic logic [7:0] store_addr(logic [3:0] row, logic [2:0] col,
                                            logic [1:0] color);
    logic [7:0] a;
    a = 8'({4'd0, row} * 8'(FRAME_COLS * COLOR_PLANES))
      + 8'({5'd0, col} * 8'(COLOR_PLANES)) + {6'd0, color};
    return a;
  endfunction

endpackage

FILE: design/led_matrix_scan_multiplexer.sv
`timescale 1ns / 1ps

// Scan multiplexer for an 11x7 RGB LED matrix driven 15 channels per scan line.
// A request with cmd low stores one pixel byte in the frame store (out-of-range
// addresses are dropped). A request with cmd high reads the 15 channel values
// of the current scan line through the fixed pixel map and returns 15 results,
// last set on the final one, then advances the line counter modulo 15. A tick
// is accepted and its channels are then read one by one through the single read
// port of the frame store; the input is stalled while the channels are being
// read. Output stall holds the read sequence. The frame store reads as zero
// after reset until a pixel is written.
module led_matrix_scan_multiplexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [3:0]  pixel_row,
  input  logic [2:0]  pixel_col,
  input  logic [1:0]  pixel_color,
  input  logic [7:0]  pixel_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel,
  output logic [15:0] gray_word,
  output logic [3:0]  line_index,
  output logic        mux_restart,
  output logic        mux_double_clock,
  output logic        last
);
  import lmsm_pkg::*;

  lmsm_cmd_t  ctl;
  lmsm_stat_t stat;

  lmsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  lmsm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .pixel_row        (pixel_row),
    .pixel_col        (pixel_col),
    .pixel_color      (pixel_color),
    .pixel_value      (pixel_value),
    .channel          (channel),
    .gray_word        (gray_word),
    .line_index       (line_index),
    .mux_restart      (mux_restart),
    .mux_double_clock (mux_double_clock),
    .last             (last)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_TICK) |=> in_stall)
    else $error("tick accepted without entering the read sequence");

  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("non-final channel shown while input is open");

  a_flags_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mux_restart || mux_double_clock)) |-> last)
    else $error("mux flag on a non-final result");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> !(out_valid && out_stall))
    else $error("read issued while output is stalled");

endmodule

FILE: design/lmsm_ctrl.sv
`timescale 1ns / 1ps

module lmsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cmd,
  input  logic               out_stall,
  input  lmsm_pkg::lmsm_stat_t stat,
  output lmsm_pkg::lmsm_cmd_t  ctl,
  output logic               in_stall,
  output logic               out_valid
);
  import lmsm_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       accept;
  logic       out_valid_next;

  assign in_stall  = (state == ST_RUN);
  assign accept    = in_valid && !in_stall;
  assign ctl.start = accept && (cmd == CMD_TICK);
  assign ctl.wr    = accept && (cmd == CMD_WRITE);
  assign ctl.issue = (state == ST_RUN) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl.start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (ctl.issue && stat.ch_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.issue) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: design/lmsm_datapath.sv
`timescale 1ns / 1ps

module lmsm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lmsm_pkg::lmsm_cmd_t  ctl,
  output lmsm_pkg::lmsm_stat_t stat,
  input  logic [3:0]         pixel_row,
  input  logic [2:0]         pixel_col,
  input  logic [1:0]         pixel_color,
  input  logic [7:0]         pixel_value,
  output logic [3:0]         channel,
  output logic [15:0]        gray_word,
  output logic [3:0]         line_index,
  output logic               mux_restart,
  output logic               mux_double_clock,
  output logic               last
);
  import lmsm_pkg::*;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [7:0]             rdata;
  logic                   rvld;

  logic [3:0] line;
  logic [3:0] line_next;
  logic [3:0] ch;
  logic [2:0] pix;
  logic [1:0] plane;

  logic       wr_ok;
  logic [7:0] waddr;
  logic [7:0] raddr;
  logic [6:0] rc;
  logic       shared;
  logic [1:0] rd_color;

  assign stat.ch_last = (ch == LAST_CHANNEL);

  assign wr_ok = ctl.wr && (pixel_row < 4'(FRAME_ROWS)) && (pixel_col < 3'(FRAME_COLS))
                 && (pixel_color < 2'(COLOR_PLANES));
  assign waddr = store_addr(pixel_row, pixel_col, pixel_color);

  assign rc       = SCAN_RC[line][pix];
  assign shared   = ((line == SHARED_LINE_A) || (line == SHARED_LINE_B)) && (pix == 3'd0);
  assign rd_color = shared ? 2'd0 : plane;
  assign raddr    = store_addr(rc[6:3], rc[2:0], rd_color);

  assign line_next = (line == LAST_LINE) ? 4'd0 : line + 4'd1;

  always_ff @(posedge clk) begin
    if (wr_ok) mem[waddr] <= pixel_value;
    if (ctl.issue) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      line    <= 4'd0;
    end else begin
      if (wr_ok) written[waddr] <= 1'b1;
      if (ctl.issue && stat.ch_last) line <= line_next;
    end
  end

  // walk channels: three planes per pixel group
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ch    <= 4'd0;
      pix   <= 3'd0;
      plane <= TOP_PLANE;
    end else if (ctl.issue) begin
      ch <= ch + 4'd1;
      if (plane == 2'd0) begin
        plane <= TOP_PLANE;
        pix   <= pix + 3'd1;
      end else begin
        plane <= plane - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rvld             <= written[raddr];
      channel          <= ch;
      line_index       <= line;
      last             <= stat.ch_last;
      mux_restart      <= stat.ch_last && (line == LAST_LINE);
      mux_double_clock <= stat.ch_last && (line == PRE_DOUBLE_LINE);
    end
  end

  assign gray_word = rvld ? {rdata, rdata} : 16'd0;

endmodule
